// ===== hdl/bgs_pkg.sv =====
//------------------------------------------------------------------------------
// bgs_pkg: shared types and constants of the glyph scaler
// Widths, request kinds, register indices and the configuration register bundle.
//------------------------------------------------------------------------------
package bgs_pkg;
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITMAP_WIDTH  = 3'd0,
		REG_BITMAP_HEIGHT = 3'd1,
		REG_READ_X_OFFSET = 3'd2,
		REG_READ_Y_OFFSET = 3'd3,
		REG_REGION_WIDTH  = 3'd4,
		REG_REGION_HEIGHT = 3'd5,
		REG_OUT_WIDTH     = 3'd6,
		REG_OUT_HEIGHT    = 3'd7
	} reg_idx_t;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic [6:0] bitmap_width;
		logic [6:0] bitmap_height;
		logic [5:0] read_x_offset;
		logic [5:0] read_y_offset;
		logic [6:0] region_width;
		logic [6:0] region_height;
		logic [6:0] out_width;
		logic [6:0] out_height;
	} cfg_t;
endpackage

// ===== hdl/bilinear_glyph_scaler.sv =====
//------------------------------------------------------------------------------
// bilinear_glyph_scaler: glyph bitmap store with a bilinear scaling sampler
//
//  channel   | signals                        | moves
//  ----------+--------------------------------+-------------------------------
//  s_axis    | s_tvalid s_tready s_tdata      | load or sample request
//  m_axis    | m_tvalid m_tready m_tdata      | scaled pixel and dest index
//  config    | cfg_we cfg_idx cfg_data        | register writes
//
//  One transaction enters per cycle unless the output holds. The pipeline
//  has FRAC_BITS+20 register stages: the input stage, the FRAC_BITS+13
//  stage bit-per-stage divider of the position map, three tap stages, two
//  blend stages and the output register. Loads ride the same pipeline and
//  write the store at the stage where samples read it, so every sample
//  sees the loads before it. Reset clears only the valid bits and loads
//  the config defaults; the pixel store is not cleared and an unwritten
//  pixel reads as anything.
//  The whole pipeline advances as one: a full output stage whose result is
//  not taken holds every stage, so nothing is dropped or repeated.
//------------------------------------------------------------------------------
module bilinear_glyph_scaler import bgs_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// req_type[0], load_index[12:1], load_pixel[20:13], out_x[26:21],
	// out_y[32:27], dest_x[44:33], dest_stride[57:45], zero pad
	input  logic [63:0]           s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_out[7:0], dest_index[26:8], zero pad
	output logic [31:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NUM_W = 13 + FRAC_BITS;    // 6-bit coord times 7-bit region
	localparam int LD_W  = 1 + 12 + 8;        // {is_load, load_index, load_pixel}

	cfg_t cfg_q;
	logic adv;
	// Two copies of the store, each serving two of the four taps
	logic [7:0] mem_a [DEPTH];
	logic [7:0] mem_b [DEPTH];

	// Register file: the user must write it only while idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{7'd64, 7'd64, 6'd0, 6'd0, 7'd64, 7'd64, 7'd64, 7'd64};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= cfg_data;
				REG_BITMAP_HEIGHT: cfg_q.bitmap_height <= cfg_data;
				REG_READ_X_OFFSET: cfg_q.read_x_offset <= cfg_data[5:0];
				REG_READ_Y_OFFSET: cfg_q.read_y_offset <= cfg_data[5:0];
				REG_REGION_WIDTH:  cfg_q.region_width  <= cfg_data;
				REG_REGION_HEIGHT: cfg_q.region_height <= cfg_data;
				REG_OUT_WIDTH:     cfg_q.out_width     <= cfg_data;
				REG_OUT_HEIGHT:    cfg_q.out_height    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance all stages unless the output holds an untaken result.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic        acc;
	logic        req;
	logic [11:0] ld_idx;
	logic [7:0]  ld_pix;
	logic [5:0]  ox, oy;
	logic [11:0] dx;
	logic [12:0] dstr;
	assign acc    = s_tvalid && s_tready;
	assign req    = s_tdata[0];
	assign ld_idx = s_tdata[12:1];
	assign ld_pix = s_tdata[20:13];
	assign ox     = s_tdata[26:21];
	assign oy     = s_tdata[32:27];
	assign dx     = s_tdata[44:33];
	assign dstr   = s_tdata[57:45];

	// Stage 1: products for the position map and the destination index;
	// every transaction enters, a load carries its index and pixel along.
	logic            vld_s1;
	logic [12:0]     pxn_s1, pyn_s1;
	logic [18:0]     didx_s1;
	logic [LD_W-1:0] ld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pxn_s1  <= 13'(ox) * 13'(cfg_q.region_width);
			pyn_s1  <= 13'(oy) * 13'(cfg_q.region_height);
			didx_s1 <= 19'(oy) * 19'(dstr) + 19'(ox) + 19'(dx);
			ld_s1   <= {req == REQ_LOAD, ld_idx, ld_pix};
		end
	end

	// Two dividers side by side; the destination index rides with X, the
	// load request with Y.
	logic             vx, vy;
	logic [NUM_W-1:0] qx, qy;
	logic [18:0]      tx;
	logic [LD_W-1:0]  ty;
	bgs_div #(.NUM_W(NUM_W), .DEN_W(7), .TAG_W(19)) u_div_x (
		.clk, .arst_n, .adv, .in_vld(vld_s1),
		.num({pxn_s1, {FRAC_BITS{1'b0}}}), .den(cfg_q.out_width),
		.tag_in(didx_s1), .out_vld(vx), .quo(qx), .tag_out(tx)
	);
	bgs_div #(.NUM_W(NUM_W), .DEN_W(7), .TAG_W(LD_W)) u_div_y (
		.clk, .arst_n, .adv, .in_vld(vld_s1),
		.num({pyn_s1, {FRAC_BITS{1'b0}}}), .den(cfg_q.out_height),
		.tag_in(ld_s1), .out_vld(vy), .quo(qy), .tag_out(ty)
	);

	// Stage T1: tap coordinates with edge clamp.
	logic [13:0] x0, y0, x1, y1;
	always_comb begin
		x0 = 14'(qx[NUM_W-1:FRAC_BITS]) + 14'(cfg_q.read_x_offset);
		y0 = 14'(qy[NUM_W-1:FRAC_BITS]) + 14'(cfg_q.read_y_offset);
		x1 = (x0 + 14'd1 >= 14'(cfg_q.bitmap_width))  ? x0 : x0 + 14'd1;
		y1 = (y0 + 14'd1 >= 14'(cfg_q.bitmap_height)) ? y0 : y0 + 14'd1;
	end

	logic               vld_t1;
	logic [13:0]        x0_t1, x1_t1, y0_t1, y1_t1;
	logic [FRAC_BITS-1:0] fx_t1, fy_t1;
	logic [18:0]        didx_t1;
	logic [LD_W-1:0]    ld_t1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_t1 <= 1'b0;
		else if (adv) vld_t1 <= vx && vy;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x0_t1 <= x0; x1_t1 <= x1; y0_t1 <= y0; y1_t1 <= y1;
			fx_t1 <= qx[FRAC_BITS-1:0];
			fy_t1 <= qy[FRAC_BITS-1:0];
			didx_t1 <= tx;
			ld_t1 <= ty;
		end
	end

	// Stage T2: linear addresses and in-bitmap flags.
	logic [27:0] a_t2 [4];
	logic        ok_t2 [4];
	logic        vld_t2;
	logic [FRAC_BITS-1:0] fx_t2, fy_t2;
	logic [18:0] didx_t2;
	logic [LD_W-1:0] ld_t2;
	logic [13:0] rows [4], cols [4];
	always_comb begin
		rows[0] = y0_t1; cols[0] = x0_t1;
		rows[1] = y0_t1; cols[1] = x1_t1;
		rows[2] = y1_t1; cols[2] = x0_t1;
		rows[3] = y1_t1; cols[3] = x1_t1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_t2 <= 1'b0;
		else if (adv) vld_t2 <= vld_t1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				a_t2[i]  <= 28'(rows[i]) * 28'(cfg_q.bitmap_width) + 28'(cols[i]);
				ok_t2[i] <= cols[i] < 14'(cfg_q.bitmap_width)
				         && rows[i] < 14'(cfg_q.bitmap_height);
			end
			fx_t2 <= fx_t1; fy_t2 <= fy_t1; didx_t2 <= didx_t1;
			ld_t2 <= ld_t1;
		end
	end

	// Stage T3: registered store reads, each gated by its flag. A load in
	// this stage writes both copies; drop it from the result path.
	logic [7:0] c_t3 [4];
	logic       ok_t3 [4];
	logic       vld_t3;
	logic [FRAC_BITS-1:0] fx_t3, fy_t3;
	logic [18:0] didx_t3;
	logic        st_t2;
	assign st_t2 = adv && vld_t2 && ld_t2[LD_W-1] && 32'(ld_t2[19:8]) < 32'(DEPTH);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_t3 <= 1'b0;
		else if (adv) vld_t3 <= vld_t2 && !ld_t2[LD_W-1];
	end
	always_ff @(posedge clk) begin
		if (st_t2) mem_a[AW'(ld_t2[19:8])] <= ld_t2[7:0];
		if (adv) begin
			c_t3[0] <= mem_a[a_t2[0][AW-1:0]];
			c_t3[1] <= mem_a[a_t2[1][AW-1:0]];
		end
	end
	always_ff @(posedge clk) begin
		if (st_t2) mem_b[AW'(ld_t2[19:8])] <= ld_t2[7:0];
		if (adv) begin
			c_t3[2] <= mem_b[a_t2[2][AW-1:0]];
			c_t3[3] <= mem_b[a_t2[3][AW-1:0]];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				ok_t3[i] <= ok_t2[i] && a_t2[i] < 28'(DEPTH);
			end
			fx_t3 <= fx_t2; fy_t3 <= fy_t2; didx_t3 <= didx_t2;
		end
	end

	logic [7:0] tap [4];
	always_comb begin
		for (int i = 0; i < 4; i++) tap[i] = ok_t3[i] ? c_t3[i] : 8'd0;
	end

	logic        bv;
	logic [7:0]  bpix;
	logic [18:0] btag;
	bgs_blend #(.FRAC_BITS(FRAC_BITS), .TAG_W(19)) u_blend (
		.clk, .arst_n, .adv, .in_vld(vld_t3),
		.c00(tap[0]), .c01(tap[1]), .c10(tap[2]), .c11(tap[3]),
		.fx(fx_t3), .fy(fy_t3), .tag_in(didx_t3),
		.out_vld(bv), .pix(bpix), .tag_out(btag)
	);

	// Output register.
	logic        ov_q;
	logic [26:0] od_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= bv;
	end
	always_ff @(posedge clk) begin
		if (adv) od_q <= {btag, bpix};
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {5'd0, od_q};
endmodule

// ===== hdl/bgs_div.sv =====
//------------------------------------------------------------------------------
// bgs_div: pipelined restoring divider
// One quotient bit per stage; a new dividend may enter every cycle while adv is high.
//------------------------------------------------------------------------------
module bgs_div import bgs_pkg::*; #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 7,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_vld,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	logic             vld_q [1:NUM_W];
	logic [NUM_W-1:0] n_q   [1:NUM_W];
	logic [DEN_W:0]   r_q   [1:NUM_W];
	logic [DEN_W-1:0] d_q   [1:NUM_W];
	logic [TAG_W-1:0] t_q   [1:NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic             v_in;
		logic [NUM_W-1:0] n_in;
		logic [DEN_W:0]   r_in;
		logic [DEN_W-1:0] d_in;
		logic [TAG_W-1:0] t_in;
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] df;

		if (k == 0) begin : g_first
			// a zero divisor divides as one
			assign v_in = in_vld;
			assign n_in = num;
			assign r_in = '0;
			assign d_in = (den == '0) ? DEN_W'(1) : den;
			assign t_in = tag_in;
		end else begin : g_next
			assign v_in = vld_q[k];
			assign n_in = n_q[k];
			assign r_in = r_q[k];
			assign d_in = d_q[k];
			assign t_in = t_q[k];
		end

		always_comb begin
			sh = {r_in, n_in[NUM_W-1]};
			df = sh - {2'b00, d_in};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (adv) begin
				vld_q[k+1] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d_q[k+1] <= d_in;
				t_q[k+1] <= t_in;
				if (!df[DEN_W+1]) begin
					r_q[k+1] <= df[DEN_W:0];
					n_q[k+1] <= {n_in[NUM_W-2:0], 1'b1};
				end else begin
					r_q[k+1] <= sh[DEN_W:0];
					n_q[k+1] <= {n_in[NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_q[NUM_W];
	assign quo     = n_q[NUM_W];
	assign tag_out = t_q[NUM_W];
endmodule

// ===== hdl/bgs_blend.sv =====
//------------------------------------------------------------------------------
// bgs_blend: two-level bilinear blend
// Horizontal pair blends, then the vertical blend, one register after each.
//------------------------------------------------------------------------------
module bgs_blend import bgs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TAG_W     = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic [7:0]           c00,
	input  logic [7:0]           c01,
	input  logic [7:0]           c10,
	input  logic [7:0]           c11,
	input  logic [FRAC_BITS-1:0] fx,
	input  logic [FRAC_BITS-1:0] fy,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 out_vld,
	output logic [7:0]           pix,
	output logic [TAG_W-1:0]     tag_out
);
	localparam int RW = FRAC_BITS + 9;
	localparam int VW = 2 * FRAC_BITS + 9;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic             vld_s1, vld_s2;
	logic [RW-1:0]    r0_s1, r1_s1;
	logic [FRAC_BITS:0] fy_s1;
	logic [TAG_W-1:0] tag_s1, tag_s2;
	logic [VW-1:0]    v_s2;
	logic [FRAC_BITS:0] fxe, ifx, ify;

	always_comb begin
		fxe = {1'b0, fx};
		ifx = ONE - fxe;
		ify = ONE - fy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r0_s1  <= RW'(ifx) * RW'(c00) + RW'(fxe) * RW'(c01);
			r1_s1  <= RW'(ifx) * RW'(c10) + RW'(fxe) * RW'(c11);
			fy_s1  <= {1'b0, fy};
			tag_s1 <= tag_in;
			v_s2   <= VW'(ify) * VW'(r0_s1) + VW'(fy_s1) * VW'(r1_s1);
			tag_s2 <= tag_s1;
		end
	end

	assign out_vld = vld_s2;
	assign pix     = v_s2[2*FRAC_BITS +: 8];
	assign tag_out = tag_s2;
endmodule
